@@ rtl/core/calendar_to_millisecond_count_defines.svh @@
// Assertion macros shared by the calendar to millisecond count block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CALENDAR_TO_MILLISECOND_COUNT_DEFINES_SVH
`define CALENDAR_TO_MILLISECOND_COUNT_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define CMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, quiet during reset.
`define CMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cmc_pkg.sv @@
// Package for the calendar to millisecond count block: widths, constants,
// stage payload types and small arithmetic helpers. No dependencies.
package cmc_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MILLI_W  = 10;
    localparam int MS_W     = 49;

    localparam int DAYS_W   = 23;
    localparam int SMALL_W  = 13;
    localparam int HOURS_W  = 28;
    localparam int MINS_W   = 34;
    localparam int SECS_W   = 39;

    localparam int Q25_W     = 8;
    localparam int Q25_IN_W  = 12;
    localparam int Q25_SHIFT = 20;
    localparam int Q25_PROD_W = Q25_IN_W + 16;
    localparam logic [Q25_PROD_W-1:0] Q25_MUL = Q25_PROD_W'(41944);

    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = DAYS_W'(365);

    typedef struct packed {
        logic [YEAR_W-1:0]   prev;
        logic [Q25_W-1:0]    p100;
        logic [Q25_W-1:0]    p400;
        logic [11:0]         y4;
        logic [Q25_W-1:0]    yq100;
        logic [9:0]          y16;
        logic [Q25_W-1:0]    yq400;
        logic [3:0]          ylo;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MILLI_W-1:0]  millisecond;
        logic                bad;
    } yd_t;

    typedef struct packed {
        logic [HOURS_W-1:0]  hours;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MILLI_W-1:0]  millisecond;
        logic                bad;
    } hr_t;

    // Quotient by 25 through a scaled reciprocal; exact for any 12-bit input.
    function automatic logic [Q25_W-1:0] div25(input logic [Q25_IN_W-1:0] x);
        logic [Q25_PROD_W-1:0] prod;
        prod = Q25_PROD_W'(x) * Q25_MUL;
        return prod[Q25_SHIFT +: Q25_W];
    endfunction

    function automatic logic [11:0] times25(input logic [Q25_W-1:0] q);
        return (12'(q) << 4) + (12'(q) << 3) + 12'(q);
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/calendar_to_millisecond_count.sv @@
// Converts a proleptic Gregorian date and time of day into milliseconds since
// 0001-01-01 00:00:00.000, with bad_date and a zero count when year, month or
// day is zero. Six register stages, one transfer in per cycle; the whole
// pipeline holds while a result waits for out_ready.
// Depends on cmc_pkg, cmc_year_div, cmc_day_count, cmc_time_scale and the
// assertion macros in calendar_to_millisecond_count_defines.svh.
`include "calendar_to_millisecond_count_defines.svh"

module calendar_to_millisecond_count (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cmc_pkg::YEAR_W-1:0]   year,
    input  logic [cmc_pkg::MONTH_W-1:0]  month,
    input  logic [cmc_pkg::DAY_W-1:0]    day,
    input  logic [cmc_pkg::HOUR_W-1:0]   hour,
    input  logic [cmc_pkg::MINUTE_W-1:0] minute,
    input  logic [cmc_pkg::SECOND_W-1:0] second,
    input  logic [cmc_pkg::MILLI_W-1:0]  millisecond,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cmc_pkg::MS_W-1:0]     ms_count,
    output logic                         bad_date
);
    import cmc_pkg::*;

    logic en;
    yd_t  yd;
    logic yd_valid;
    hr_t  hr;
    logic hr_valid;

    // advance every stage unless a finished result is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    cmc_year_div u_year_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .millisecond (millisecond),
        .yd          (yd),
        .yd_valid    (yd_valid)
    );

    cmc_day_count u_day_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .yd       (yd),
        .yd_valid (yd_valid),
        .hr       (hr),
        .hr_valid (hr_valid)
    );

    cmc_time_scale u_time_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .hr       (hr),
        .hr_valid (hr_valid),
        .ms_count (ms_count),
        .bad_date (bad_date),
        .ms_valid (out_valid)
    );

    `CMC_ASSERT_IMPLY(a_bad_zero, clk, rst_n, out_valid && bad_date, ms_count == '0, "bad date with non-zero count")
    `CMC_ASSERT_IMPLY(a_empty_ready, clk, rst_n, !out_valid, in_ready, "empty output blocks input")
    `CMC_ASSERT_IMPLY(a_stall_holds, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken during output stall")

endmodule

@@ rtl/core/cmc_year_div.sv @@
// First stage: elapsed years and their quotients by 100 and 400, plus the
// year quotients used for the leap test. Depends on cmc_pkg.
module cmc_year_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cmc_pkg::YEAR_W-1:0]   year,
    input  logic [cmc_pkg::MONTH_W-1:0]  month,
    input  logic [cmc_pkg::DAY_W-1:0]    day,
    input  logic [cmc_pkg::HOUR_W-1:0]   hour,
    input  logic [cmc_pkg::MINUTE_W-1:0] minute,
    input  logic [cmc_pkg::SECOND_W-1:0] second,
    input  logic [cmc_pkg::MILLI_W-1:0]  millisecond,
    output cmc_pkg::yd_t                 yd,
    output logic                         yd_valid
);
    import cmc_pkg::*;

    yd_t  yd_reg;
    yd_t  yd_next;
    logic valid_reg;

    always_comb
    begin
        yd_next.prev        = year - YEAR_W'(1);
        yd_next.p100        = div25(Q25_IN_W'(yd_next.prev >> 2));
        yd_next.p400        = div25(Q25_IN_W'(yd_next.prev >> 4));
        yd_next.y4          = 12'(year >> 2);
        yd_next.yq100       = div25(yd_next.y4);
        yd_next.y16         = 10'(year >> 4);
        yd_next.yq400       = div25(Q25_IN_W'(yd_next.y16));
        yd_next.ylo         = year[3:0];
        yd_next.month       = month;
        yd_next.day         = day;
        yd_next.hour        = hour;
        yd_next.minute      = minute;
        yd_next.second      = second;
        yd_next.millisecond = millisecond;
        yd_next.bad         = (year == '0) || (month == '0) || (day == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yd_reg <= yd_next;
        end
    end

    assign yd       = yd_reg;
    assign yd_valid = valid_reg;

endmodule

@@ rtl/core/cmc_day_count.sv @@
// Second and third stages: day number from year, month and day, then hours.
// Depends on cmc_pkg.
module cmc_day_count (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  cmc_pkg::yd_t yd,
    input  logic         yd_valid,
    output cmc_pkg::hr_t hr,
    output logic         hr_valid
);
    import cmc_pkg::*;

    logic [DAYS_W-1:0]   base_reg;
    logic [DAYS_W-1:0]   base_next;
    logic [SMALL_W-1:0]  small_reg;
    logic [SMALL_W-1:0]  small_next;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;
    logic [MILLI_W-1:0]  milli_reg;
    logic                bad_reg;
    logic                v2_reg;
    logic                leap;
    logic                leap_add;
    logic [DAYS_W-1:0]   days;
    hr_t                 hr_reg;
    hr_t                 hr_next;
    logic                v3_reg;

    always_comb
    begin
        leap = (yd.ylo[1:0] == 2'b00)
            && ((times25(yd.yq100) != yd.y4)
                || ((yd.ylo == 4'b0000) && (times25(yd.yq400) == 12'(yd.y16))));
        leap_add   = leap && (yd.month > MONTH_W'(2));
        base_next  = DAYS_W'(yd.prev) * DAYS_PER_YEAR;
        small_next = SMALL_W'(yd.prev >> 2) - SMALL_W'(yd.p100) + SMALL_W'(yd.p400)
                   + SMALL_W'(days_before(yd.month)) + SMALL_W'(leap_add)
                   + SMALL_W'(yd.day) - SMALL_W'(1);
    end

    always_comb
    begin
        days                = base_reg + DAYS_W'(small_reg);
        hr_next.hours       = (HOURS_W'(days) << 4) + (HOURS_W'(days) << 3)
                            + HOURS_W'(hour_reg);
        hr_next.minute      = minute_reg;
        hr_next.second      = second_reg;
        hr_next.millisecond = milli_reg;
        hr_next.bad         = bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= yd_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg   <= base_next;
            small_reg  <= small_next;
            hour_reg   <= yd.hour;
            minute_reg <= yd.minute;
            second_reg <= yd.second;
            milli_reg  <= yd.millisecond;
            bad_reg    <= yd.bad;
            hr_reg     <= hr_next;
        end
    end

    assign hr       = hr_reg;
    assign hr_valid = v3_reg;

endmodule

@@ rtl/core/cmc_time_scale.sv @@
// Last three stages: scale hours to minutes, seconds and milliseconds.
// Depends on cmc_pkg; the final stage is the output register.
module cmc_time_scale (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  cmc_pkg::hr_t             hr,
    input  logic                     hr_valid,
    output logic [cmc_pkg::MS_W-1:0] ms_count,
    output logic                     bad_date,
    output logic                     ms_valid
);
    import cmc_pkg::*;

    logic [MINS_W-1:0]   mins_reg;
    logic [MINS_W-1:0]   mins_next;
    logic [SECOND_W-1:0] sec4_reg;
    logic [MILLI_W-1:0]  milli4_reg;
    logic                bad4_reg;
    logic                v4_reg;
    logic [SECS_W-1:0]   secs_reg;
    logic [SECS_W-1:0]   secs_next;
    logic [MILLI_W-1:0]  milli5_reg;
    logic                bad5_reg;
    logic                v5_reg;
    logic [MS_W-1:0]     ms_reg;
    logic [MS_W-1:0]     ms_next;
    logic                bad6_reg;
    logic                v6_reg;

    always_comb
    begin
        mins_next = (MINS_W'(hr.hours) << 6) - (MINS_W'(hr.hours) << 2)
                  + MINS_W'(hr.minute);
        secs_next = (SECS_W'(mins_reg) << 6) - (SECS_W'(mins_reg) << 2)
                  + SECS_W'(sec4_reg);
        ms_next   = (MS_W'(secs_reg) << 10) - (MS_W'(secs_reg) << 4)
                  - (MS_W'(secs_reg) << 3) + MS_W'(milli5_reg);
        if (bad5_reg)
        begin
            ms_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= hr_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mins_reg   <= mins_next;
            sec4_reg   <= hr.second;
            milli4_reg <= hr.millisecond;
            bad4_reg   <= hr.bad;
            secs_reg   <= secs_next;
            milli5_reg <= milli4_reg;
            bad5_reg   <= bad4_reg;
            ms_reg     <= ms_next;
            bad6_reg   <= bad5_reg;
        end
    end

    assign ms_count = ms_reg;
    assign bad_date = bad6_reg;
    assign ms_valid = v6_reg;

endmodule
